// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/wsd_pkg.sv -----
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and constants of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR1    = 3'd0,
    PH_HDR2    = 3'd1,
    PH_EXT     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_FAILED  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_ERROR    = 2'd2,
    KIND_OVERSIZE = 2'd3
  } kind_t;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam int unsigned LEN_W = 63;

  localparam logic [6:0]       LEN7_EXT16        = 7'd126;
  localparam logic [6:0]       LEN7_EXT64        = 7'd127;
  localparam logic [63:0]      EXT16_MIN         = 64'd126;
  localparam logic [63:0]      EXT64_MIN         = 64'd65536;
  localparam logic [63:0]      CONTROL_MAX       = 64'd125;
  localparam logic [LEN_W-1:0] PAYLOAD_LIMIT_RST = 63'd65536;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload;
    logic [3:0] opcode;
    logic       final_bit;
    logic       last;
  } result_t;

  function automatic logic opcode_known(input logic [3:0] op);
    return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BINARY) ||
           (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/wsd_parser.sv -----
// ----------------------------------------------------------------------------
// wsd_parser
// Header parse state, length checks and payload tagging, one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module wsd_parser (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      step_en,
  input  wire logic [7:0]                step_byte,
  input  wire logic                      cfg_we,
  input  wire logic [wsd_pkg::LEN_W-1:0] cfg_value,
  output logic                           res_valid,
  output wsd_pkg::result_t               res
);

  wsd_pkg::phase_t           phase_r, phase_nxt;
  logic [7:0]                held_r, held_nxt;
  logic [3:0]                ext_left_r, ext_left_nxt;
  logic                      ext_wide_r, ext_wide_nxt;
  logic [55:0]               accum_r, accum_nxt;
  logic [wsd_pkg::LEN_W-1:0] left_r, left_nxt;
  logic [wsd_pkg::LEN_W-1:0] max_r, max_nxt;

  logic [6:0]   len7;
  logic [63:0]  ext_len;
  logic [63:0]  fin_len;
  logic         hdr_bad;
  logic         ext_bad;
  logic         is_control;
  logic         do_finish;
  wsd_pkg::kind_t res_kind;
  logic [7:0]   res_byte;
  logic         res_last;

  assign len7       = step_byte[6:0];
  assign ext_len    = {accum_r, step_byte};
  assign fin_len    = (phase_r == wsd_pkg::PH_EXT) ? ext_len : {57'd0, len7};
  assign hdr_bad    = (held_r[6:4] != 3'd0) || !wsd_pkg::opcode_known(held_r[3:0]);
  assign ext_bad    = ext_wide_r ? (ext_len[63] || (ext_len < wsd_pkg::EXT64_MIN))
                                 : (ext_len < wsd_pkg::EXT16_MIN);
  // known opcodes with bit 3 set are the control frames
  assign is_control = held_r[3];

  always_comb begin
    phase_nxt    = phase_r;
    held_nxt     = held_r;
    ext_left_nxt = ext_left_r;
    ext_wide_nxt = ext_wide_r;
    accum_nxt    = accum_r;
    left_nxt     = left_r;
    max_nxt      = cfg_we ? cfg_value : max_r;
    do_finish    = 1'b0;
    res_valid    = 1'b0;
    res_kind     = wsd_pkg::KIND_DATA;
    res_byte     = 8'd0;
    res_last     = 1'b0;

    if (step_en) begin
      unique case (phase_r)
        wsd_pkg::PH_HDR1: begin
          held_nxt  = step_byte;
          phase_nxt = wsd_pkg::PH_HDR2;
        end
        wsd_pkg::PH_HDR2: begin
          priority if (hdr_bad || step_byte[7]) begin
            res_valid = 1'b1;
            res_kind  = wsd_pkg::KIND_ERROR;
            phase_nxt = wsd_pkg::PH_FAILED;
          end else if ((len7 == wsd_pkg::LEN7_EXT16) || (len7 == wsd_pkg::LEN7_EXT64)) begin
            ext_wide_nxt = (len7 == wsd_pkg::LEN7_EXT64);
            ext_left_nxt = (len7 == wsd_pkg::LEN7_EXT64) ? 4'd8 : 4'd2;
            accum_nxt    = '0;
            phase_nxt    = wsd_pkg::PH_EXT;
          end else begin
            do_finish = 1'b1;
          end
        end
        wsd_pkg::PH_EXT: begin
          accum_nxt    = ext_len[55:0];
          ext_left_nxt = ext_left_r - 4'd1;
          if (ext_left_r == 4'd1) begin
            if (ext_bad) begin
              res_valid = 1'b1;
              res_kind  = wsd_pkg::KIND_ERROR;
              phase_nxt = wsd_pkg::PH_FAILED;
            end else begin
              do_finish = 1'b1;
            end
          end
        end
        wsd_pkg::PH_PAYLOAD: begin
          res_valid = 1'b1;
          res_kind  = wsd_pkg::KIND_DATA;
          res_byte  = step_byte;
          res_last  = (left_r == {{(wsd_pkg::LEN_W-1){1'b0}}, 1'b1});
          left_nxt  = left_r - {{(wsd_pkg::LEN_W-1){1'b0}}, 1'b1};
          if (res_last) begin
            phase_nxt = wsd_pkg::PH_HDR1;
          end
        end
        wsd_pkg::PH_FAILED: begin
        end
        default: begin
        end
      endcase

      // checks shared by all length forms
      if (do_finish) begin
        priority if (fin_len[63] || (fin_len[62:0] > max_r)) begin
          res_valid = 1'b1;
          res_kind  = wsd_pkg::KIND_OVERSIZE;
          phase_nxt = wsd_pkg::PH_FAILED;
        end else if (is_control && (!held_r[7] || (fin_len > wsd_pkg::CONTROL_MAX))) begin
          res_valid = 1'b1;
          res_kind  = wsd_pkg::KIND_ERROR;
          phase_nxt = wsd_pkg::PH_FAILED;
        end else if ((held_r[3:0] == wsd_pkg::OP_CLOSE) && (fin_len == 64'd1)) begin
          res_valid = 1'b1;
          res_kind  = wsd_pkg::KIND_ERROR;
          phase_nxt = wsd_pkg::PH_FAILED;
        end else if (fin_len == 64'd0) begin
          res_valid = 1'b1;
          res_kind  = wsd_pkg::KIND_EMPTY;
          res_last  = 1'b1;
          phase_nxt = wsd_pkg::PH_HDR1;
        end else begin
          left_nxt  = fin_len[62:0];
          phase_nxt = wsd_pkg::PH_PAYLOAD;
        end
      end
    end
  end

  assign res.kind      = res_kind;
  assign res.payload   = res_byte;
  assign res.opcode    = held_r[3:0];
  assign res.final_bit = held_r[7];
  assign res.last      = res_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= wsd_pkg::PH_HDR1;
      ext_left_r <= 4'd0;
      max_r      <= wsd_pkg::PAYLOAD_LIMIT_RST;
    end else begin
      phase_r    <= phase_nxt;
      ext_left_r <= ext_left_nxt;
      max_r      <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r     <= held_nxt;
    ext_wide_r <= ext_wide_nxt;
    accum_r    <= accum_nxt;
    left_r     <= left_nxt;
  end

  `ASSERT_NEXT(a_failed_sticky, phase_r == wsd_pkg::PH_FAILED, phase_r == wsd_pkg::PH_FAILED)
  `ASSERT_IMPL(a_failed_silent, phase_r == wsd_pkg::PH_FAILED, !res_valid)
  `ASSERT_NEXT(a_error_fails,
               step_en && res_valid &&
               ((res_kind == wsd_pkg::KIND_ERROR) || (res_kind == wsd_pkg::KIND_OVERSIZE)),
               phase_r == wsd_pkg::PH_FAILED)

endmodule

`default_nettype wire

// ----- rtl/core/wsd_out_reg.sv -----
// ----------------------------------------------------------------------------
// wsd_out_reg
// Result register toward the output stream; frees itself as it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_out_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire wsd_pkg::result_t load_res,
  output logic                  room,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output wsd_pkg::result_t      out_res
);

  logic             valid_r, valid_nxt;
  wsd_pkg::result_t res_r;

  assign room      = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/websocket_frame_deframer.sv -----
// An accepted input byte is held in the input register; its result, if any, is then loaded into the result register.
// Throughput: 1 byte per cycle; the input register and the result register each
// hold one transaction, and both advance whenever the result register is free or taken.
// Reset (rst_n low, synchronous): parser back to first header byte, both stages
// empty, payload length limit back to 65536.
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses a server-to-client WebSocket byte stream and forwards tagged payload.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module websocket_frame_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] payload_byte, [11:8] frame_opcode,
                                       // [12] frame_final, [15:13] zero
  output logic             out_tlast,  // frame_last
  output logic [1:0]       out_tuser,  // [1:0] result_kind
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [62:0] cfg_data    // payload length limit
);

  logic             in_valid_r, in_valid_nxt;
  logic [7:0]       in_byte_r;
  logic             room;
  logic             step_en;
  logic             in_fire;
  logic             res_valid;
  wsd_pkg::result_t res;
  wsd_pkg::result_t out_res;

  assign step_en   = in_valid_r && room;
  assign in_tready = !in_valid_r || room;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign in_valid_nxt = in_fire ? 1'b1 : (step_en ? 1'b0 : in_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_tdata;
    end
  end

  wsd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .step_byte (in_byte_r),
    .cfg_we    (cfg_valid),
    .cfg_value (cfg_data),
    .res_valid (res_valid),
    .res       (res)
  );

  wsd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_en && res_valid),
    .load_res  (res),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {3'd0, out_res.final_bit, out_res.opcode, out_res.payload};
  assign out_tlast = out_res.last;
  assign out_tuser = out_res.kind;

  // a held byte waiting on a full result register is not dropped
  `ASSERT_NEXT(a_in_hold, in_valid_r && !room, in_valid_r)

endmodule

`default_nettype wire
